/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers with active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every rising clock edge outside reset.
`define CPUALU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Assert that a condition never holds outside reset.
`define CPUALU_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* hdl/cpualu_pkg.sv */
// ----------------------------------------------------------------------------
// cpualu_pkg
// Types, codes and constants of the 8-bit CPU ALU.
// ----------------------------------------------------------------------------
package cpualu_pkg;

  localparam int unsigned KIND_W  = 5;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FLAGS_W = 4;
  localparam int unsigned WIDE_W  = 16;

  typedef enum logic [KIND_W-1:0] {
    K_ADD    = 5'd0,
    K_ADC    = 5'd1,
    K_SUB    = 5'd2,
    K_SBC    = 5'd3,
    K_AND    = 5'd4,
    K_XOR    = 5'd5,
    K_OR     = 5'd6,
    K_CP     = 5'd7,
    K_INC    = 5'd8,
    K_DEC    = 5'd9,
    K_DAA    = 5'd10,
    K_CPL    = 5'd11,
    K_SCF    = 5'd12,
    K_CCF    = 5'd13,
    K_RLCA   = 5'd14,
    K_RRCA   = 5'd15,
    K_RLA    = 5'd16,
    K_RRA    = 5'd17,
    K_ADD16  = 5'd18,
    K_SP_OFS = 5'd19
  } kind_e;

  localparam logic [BYTE_W-1:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [BYTE_W-1:0] DAA_HI_ADJ   = 8'h60;
  localparam logic [BYTE_W-1:0] DAA_LO_ADJ   = 8'h06;
  localparam logic [3:0]        DAA_LO_LIMIT = 4'h9;
  localparam logic [BYTE_W-1:0] CPL_MASK     = 8'hFF;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  accumulator;
    logic [BYTE_W-1:0]  operand;
    logic [FLAGS_W-1:0] flags_in;
    logic [WIDE_W-1:0]  wide_first;
    logic [WIDE_W-1:0]  wide_second;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  result;
    logic [WIDE_W-1:0]  wide_result;
    logic [FLAGS_W-1:0] flags_out;
  } rsp_t;

endpackage

/* hdl/cpualu_in_if.sv */
// ----------------------------------------------------------------------------
// cpualu_in_if
// Operation channel of the CPU ALU: valid/ready with operands and flags.
// ----------------------------------------------------------------------------
interface cpualu_in_if;
  import cpualu_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [BYTE_W-1:0]  accumulator;
  logic [BYTE_W-1:0]  operand;
  logic [FLAGS_W-1:0] flags_in;
  logic [WIDE_W-1:0]  wide_first;
  logic [WIDE_W-1:0]  wide_second;

  modport source (
    output valid, kind, accumulator, operand, flags_in, wide_first, wide_second,
    input  ready
  );

  modport sink (
    input  valid, kind, accumulator, operand, flags_in, wide_first, wide_second,
    output ready
  );
endinterface

/* hdl/cpualu_out_if.sv */
// ----------------------------------------------------------------------------
// cpualu_out_if
// Result channel of the CPU ALU: valid/ready with results and flags.
// ----------------------------------------------------------------------------
interface cpualu_out_if;
  import cpualu_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  result;
  logic [WIDE_W-1:0]  wide_result;
  logic [FLAGS_W-1:0] flags_out;

  modport source (
    output valid, result, wide_result, flags_out,
    input  ready
  );

  modport sink (
    input  valid, result, wide_result, flags_out,
    output ready
  );
endinterface

/* hdl/cpualu_core.sv */
// ----------------------------------------------------------------------------
// cpualu_core
// Combinational datapath: 8-bit ALU, DAA, rotates, 16-bit adds and flags.
// ----------------------------------------------------------------------------
module cpualu_core (
  input  cpualu_pkg::req_t req_i,
  output cpualu_pkg::rsp_t rsp_o
);
  import cpualu_pkg::*;

  kind_e              kind;
  flags_t             fin;
  logic [BYTE_W-1:0]  a;
  logic [BYTE_W-1:0]  b;
  logic               add_t;
  logic               sub_t;
  logic [BYTE_W:0]    add_sum;
  logic [4:0]         add_half;
  logic [BYTE_W:0]    sub_diff;
  logic [4:0]         sub_half;
  logic [BYTE_W-1:0]  inc_res;
  logic [BYTE_W-1:0]  dec_res;
  logic [BYTE_W-1:0]  daa_mid;
  logic [BYTE_W-1:0]  daa_res;
  logic               daa_c;
  logic [WIDE_W:0]    pair_sum;
  logic [12:0]        pair_half;
  logic [WIDE_W-1:0]  sp_sum;
  logic [BYTE_W:0]    sp_low;
  logic [4:0]         sp_half;
  logic [BYTE_W-1:0]  r;
  logic [WIDE_W-1:0]  w;
  flags_t             fo;

  assign kind = kind_e'(req_i.kind);
  assign fin  = flags_t'(req_i.flags_in);
  assign a    = req_i.accumulator;
  assign b    = req_i.operand;

  assign add_t    = (kind == K_ADC) && fin.c;
  assign sub_t    = (kind == K_SBC) && fin.c;
  assign add_sum  = {1'b0, a} + {1'b0, b} + {{BYTE_W{1'b0}}, add_t};
  assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, add_t};
  assign sub_diff = {1'b0, a} - {1'b0, b} - {{BYTE_W{1'b0}}, sub_t};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, sub_t};
  assign inc_res  = b + 8'd1;
  assign dec_res  = b - 8'd1;

  assign pair_sum  = {1'b0, req_i.wide_first} + {1'b0, req_i.wide_second};
  assign pair_half = {1'b0, req_i.wide_first[11:0]} + {1'b0, req_i.wide_second[11:0]};
  assign sp_sum    = req_i.wide_first + {{(WIDE_W-BYTE_W){b[BYTE_W-1]}}, b};
  assign sp_low    = {1'b0, req_i.wide_first[BYTE_W-1:0]} + {1'b0, b};
  assign sp_half   = {1'b0, req_i.wide_first[3:0]} + {1'b0, b[3:0]};

  always_comb begin
    daa_c   = fin.c;
    daa_mid = a;
    daa_res = a;
    if (!fin.n) begin
      if (fin.c || (a > DAA_HI_LIMIT)) begin
        daa_mid = a + DAA_HI_ADJ;
        daa_c   = 1'b1;
      end
      daa_res = (fin.h || (a[3:0] > DAA_LO_LIMIT)) ? daa_mid + DAA_LO_ADJ : daa_mid;
    end else begin
      daa_mid = fin.c ? a - DAA_HI_ADJ : a;
      daa_res = fin.h ? daa_mid - DAA_LO_ADJ : daa_mid;
    end
  end

  always_comb begin
    r  = a;
    w  = '0;
    fo = fin;
    unique case (kind)
      K_ADD, K_ADC: begin
        r  = add_sum[BYTE_W-1:0];
        fo = '{z: ~|add_sum[BYTE_W-1:0], n: 1'b0, h: add_half[4], c: add_sum[BYTE_W]};
      end
      K_SUB, K_SBC, K_CP: begin
        r  = (kind == K_CP) ? a : sub_diff[BYTE_W-1:0];
        fo = '{z: ~|sub_diff[BYTE_W-1:0], n: 1'b1, h: sub_half[4], c: sub_diff[BYTE_W]};
      end
      K_AND: begin
        r  = a & b;
        fo = '{z: ~|(a & b), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      K_XOR: begin
        r  = a ^ b;
        fo = '{z: ~|(a ^ b), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      K_OR: begin
        r  = a | b;
        fo = '{z: ~|(a | b), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      K_INC: begin
        r  = inc_res;
        fo = '{z: ~|inc_res, n: 1'b0, h: &b[3:0], c: fin.c};
      end
      K_DEC: begin
        r  = dec_res;
        fo = '{z: ~|dec_res, n: 1'b1, h: ~|b[3:0], c: fin.c};
      end
      K_DAA: begin
        r  = daa_res;
        fo = '{z: ~|daa_res, n: fin.n, h: 1'b0, c: daa_c};
      end
      K_CPL: begin
        r  = a ^ CPL_MASK;
        fo = '{z: fin.z, n: 1'b1, h: 1'b1, c: fin.c};
      end
      K_SCF: begin
        fo = '{z: fin.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      K_CCF: begin
        fo = '{z: fin.z, n: 1'b0, h: 1'b0, c: ~fin.c};
      end
      K_RLCA: begin
        r  = {a[BYTE_W-2:0], a[BYTE_W-1]};
        fo = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[BYTE_W-1]};
      end
      K_RRCA: begin
        r  = {a[0], a[BYTE_W-1:1]};
        fo = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      K_RLA: begin
        r  = {a[BYTE_W-2:0], fin.c};
        fo = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[BYTE_W-1]};
      end
      K_RRA: begin
        r  = {fin.c, a[BYTE_W-1:1]};
        fo = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      K_ADD16: begin
        w  = pair_sum[WIDE_W-1:0];
        fo = '{z: fin.z, n: 1'b0, h: pair_half[12], c: pair_sum[WIDE_W]};
      end
      K_SP_OFS: begin
        w  = sp_sum;
        fo = '{z: 1'b0, n: 1'b0, h: sp_half[4], c: sp_low[BYTE_W]};
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.result      = r;
  assign rsp_o.wide_result = w;
  assign rsp_o.flags_out   = fo;

endmodule

/* hdl/cpu_alu_with_flags.sv */
// ----------------------------------------------------------------------------
// cpu_alu_with_flags
// Path: an accepted item enters the input register, its result the result register.
// Throughput: 1 item per cycle unless the result stalls; the combinational ALU path
// between the two registers sets the rate. A stalled result holds the result register; the
// input register still takes one item while it is empty.
// Reset: asynchronous, active low; clears both valid bits, no item in flight.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags (
  input  logic        clk_i,
  input  logic        rst_ni,
  cpualu_in_if.sink   in_i,
  cpualu_out_if.source out_o
);
  import cpualu_pkg::*;

  logic s1_valid_q;
  logic s2_valid_q;
  logic s1_ready;
  logic s2_ready;
  req_t req_in;
  req_t s1_req_q;
  rsp_t rsp;
  rsp_t s2_rsp_q;

  assign s2_ready = !s2_valid_q || out_o.ready;
  assign s1_ready = !s1_valid_q || s2_ready;

  assign req_in = '{
    kind:        in_i.kind,
    accumulator: in_i.accumulator,
    operand:     in_i.operand,
    flags_in:    in_i.flags_in,
    wide_first:  in_i.wide_first,
    wide_second: in_i.wide_second
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && s1_ready) begin
      s1_req_q <= req_in;
    end
    if (s1_valid_q && s2_ready) begin
      s2_rsp_q <= rsp;
    end
  end

  cpualu_core u_core (
    .req_i (s1_req_q),
    .rsp_o (rsp)
  );

  assign in_i.ready        = s1_ready;
  assign out_o.valid       = s2_valid_q;
  assign out_o.result      = s2_rsp_q.result;
  assign out_o.wide_result = s2_rsp_q.wide_result;
  assign out_o.flags_out   = s2_rsp_q.flags_out;

endmodule

/* hdl/cpualu_checker.sv */
// ----------------------------------------------------------------------------
// cpualu_checker
// Port-level checks of the CPU ALU: item count in flight and result handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpualu_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [cpualu_pkg::BYTE_W-1:0]  out_result_i,
  input logic [cpualu_pkg::WIDE_W-1:0]  out_wide_result_i,
  input logic [cpualu_pkg::FLAGS_W-1:0] out_flags_i
);
  import cpualu_pkg::*;

  localparam int unsigned PAY_W = BYTE_W + WIDE_W + FLAGS_W;

  logic             in_acc;
  logic             out_acc;
  logic [1:0]       cnt_q;
  logic [1:0]       cnt_d;
  logic [PAY_W-1:0] out_pay;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign out_pay = {out_result_i, out_wide_result_i, out_flags_i};
  assign cnt_d   = cnt_q + {1'b0, in_acc} - {1'b0, out_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `CPUALU_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pay))
  `CPUALU_ASSERT(a_idle_after_reset, clk_i, rst_ni, $rose(rst_ni) |-> !out_valid_i)
  `CPUALU_NEVER(a_no_phantom, clk_i, rst_ni, out_valid_i && (cnt_q == 2'd0))
  `CPUALU_NEVER(a_depth, clk_i, rst_ni, cnt_q == 2'd3)

endmodule

bind cpu_alu_with_flags cpualu_checker u_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_result_i      (out_o.result),
  .out_wide_result_i (out_o.wide_result),
  .out_flags_i       (out_o.flags_out)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 8-bit CPU ALU with flags: a directed pass over
// every operation and corner case, then random operations under four
// source/sink throttling phases, each result checked against a local model.
// ----------------------------------------------------------------------------
module tb_top;
  import cpualu_pkg::*;

  localparam int unsigned    NUM_ITEMS     = 1700;
  localparam int unsigned    NUM_PHASES    = 4;
  localparam int unsigned    DRAIN_CYCLES  = 8;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 5'd20;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 5'd31;

  class alu_checker;
    rsp_t pending_rsp[$];
    int   mismatches;

    function new();
      mismatches = 0;
    endfunction

    function rsp_t alu_eval(req_t q);
      int unsigned ia, ib, ic, t, s, w1, w2;
      logic [BYTE_W-1:0] a, r;
      logic [WIDE_W-1:0] w;
      logic z, n, h, c;
      a  = q.accumulator;
      ia = q.accumulator;
      ib = q.operand;
      ic = q.flags_in[0];
      w1 = q.wide_first;
      w2 = q.wide_second;
      r  = a;
      w  = '0;
      {z, n, h, c} = q.flags_in;
      case (q.kind)
        K_ADD, K_ADC: begin
          t = (q.kind == K_ADC) ? ic : 0;
          s = ia + ib + t;
          r = s[7:0];
          z = (r == 0);
          n = 1'b0;
          h = ((ia & 15) + (ib & 15) + t) > 15;
          c = s > 255;
        end
        K_SUB, K_SBC, K_CP: begin
          t = (q.kind == K_SBC) ? ic : 0;
          s = ia - ib - t;
          r = s[7:0];
          z = (r == 0);
          n = 1'b1;
          h = (ia & 15) < ((ib & 15) + t);
          c = ia < (ib + t);
          if (q.kind == K_CP) r = a;
        end
        K_AND: begin
          r = a & q.operand;
          {z, n, h, c} = {r == 0, 1'b0, 1'b1, 1'b0};
        end
        K_XOR: begin
          r = a ^ q.operand;
          {z, n, h, c} = {r == 0, 3'b000};
        end
        K_OR: begin
          r = a | q.operand;
          {z, n, h, c} = {r == 0, 3'b000};
        end
        K_INC: begin
          r = q.operand + 8'd1;
          z = (r == 0);
          n = 1'b0;
          h = (q.operand[3:0] == 4'hF);
        end
        K_DEC: begin
          r = q.operand - 8'd1;
          z = (r == 0);
          n = 1'b1;
          h = (q.operand[3:0] == 4'h0);
        end
        K_DAA: begin
          if (!n) begin
            if (c || a > DAA_HI_LIMIT) begin
              r = r + DAA_HI_ADJ;
              c = 1'b1;
            end
            if (h || a[3:0] > DAA_LO_LIMIT) r = r + DAA_LO_ADJ;
          end else begin
            if (c) r = r - DAA_HI_ADJ;
            if (h) r = r - DAA_LO_ADJ;
          end
          z = (r == 0);
          h = 1'b0;
        end
        K_CPL: begin
          r = a ^ CPL_MASK;
          n = 1'b1;
          h = 1'b1;
        end
        K_SCF: {n, h, c} = 3'b001;
        K_CCF: {n, h, c} = {2'b00, ~c};
        K_RLCA: begin
          r = {a[6:0], a[7]};
          {z, n, h, c} = {3'b000, a[7]};
        end
        K_RRCA: begin
          r = {a[0], a[7:1]};
          {z, n, h, c} = {3'b000, a[0]};
        end
        K_RLA: begin
          r = {a[6:0], q.flags_in[0]};
          {z, n, h, c} = {3'b000, a[7]};
        end
        K_RRA: begin
          r = {q.flags_in[0], a[7:1]};
          {z, n, h, c} = {3'b000, a[0]};
        end
        K_ADD16: begin
          s = w1 + w2;
          w = s[15:0];
          n = 1'b0;
          h = ((w1 & 'hFFF) + (w2 & 'hFFF)) > 'hFFF;
          c = s > 'hFFFF;
        end
        K_SP_OFS: begin
          w = q.wide_first + {{8{q.operand[7]}}, q.operand};
          z = 1'b0;
          n = 1'b0;
          h = ((w1 & 15) + (ib & 15)) > 15;
          c = ((w1 & 255) + ib) > 255;
        end
        default: ;
      endcase
      return '{result: r, wide_result: w, flags_out: {z, n, h, c}};
    endfunction

    function void note_item(req_t q);
      pending_rsp.push_back(alu_eval(q));
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("ERROR at %0t: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        report("unexpected result", got, 0);
      end else begin
        want = pending_rsp.pop_front();
        if (got.result !== want.result) report("result", got.result, want.result);
        if (got.wide_result !== want.wide_result)
          report("wide_result", got.wide_result, want.wide_result);
        if (got.flags_out !== want.flags_out)
          report("flags_out", got.flags_out, want.flags_out);
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned idle_pct;
  int unsigned stall_pct;
  alu_checker  alu_check = new();

  cpualu_in_if  in_if ();
  cpualu_out_if out_if ();

  cpu_alu_with_flags i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        alu_check.note_item('{kind: in_if.kind, accumulator: in_if.accumulator,
                              operand: in_if.operand, flags_in: in_if.flags_in,
                              wide_first: in_if.wide_first,
                              wide_second: in_if.wide_second});
      end
      if (out_if.valid && out_if.ready) begin
        alu_check.check_result('{result: out_if.result,
                                 wide_result: out_if.wide_result,
                                 flags_out: out_if.flags_out});
      end
    end
  end

  function automatic req_t mk_req(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] a,
                                  logic [BYTE_W-1:0] b, logic [FLAGS_W-1:0] f,
                                  logic [WIDE_W-1:0] w1, logic [WIDE_W-1:0] w2);
    return '{kind: kind, accumulator: a, operand: b, flags_in: f,
             wide_first: w1, wide_second: w2};
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    logic [BYTE_W-1:0] corners[8] = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'h99, 8'hFF};
    if ($urandom_range(3) == 0) return corners[3'($urandom_range(7))];
    return BYTE_W'($urandom_range(255));
  endfunction

  function automatic logic [WIDE_W-1:0] pick_wide();
    logic [WIDE_W-1:0] corners[6] = '{16'h0000, 16'h000F, 16'h00FF, 16'h0FFF, 16'h8000,
                                      16'hFFFF};
    if ($urandom_range(3) == 0) return corners[3'($urandom_range(5))];
    return WIDE_W'($urandom_range(65535));
  endfunction

  function automatic req_t rand_req();
    logic [KIND_W-1:0] kind;
    if ($urandom_range(99) < 4) kind = KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
    else kind = KIND_W'($urandom_range(K_SP_OFS, K_ADD));
    return mk_req(kind, pick_byte(), pick_byte(), FLAGS_W'($urandom_range(15)), pick_wide(),
                  pick_wide());
  endfunction

  task automatic send_item(req_t q);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= q.kind;
    in_if.accumulator <= q.accumulator;
    in_if.operand     <= q.operand;
    in_if.flags_in    <= q.flags_in;
    in_if.wide_first  <= q.wide_first;
    in_if.wide_second <= q.wide_second;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  initial begin
    req_t        directed[$];
    int unsigned idle_tbl[NUM_PHASES]  = '{0, 68, 0, 34};
    int unsigned stall_tbl[NUM_PHASES] = '{0, 0, 68, 34};

    rst_ni             = 1'b0;
    idle_pct           = 0;
    stall_pct          = 0;
    in_if.valid        = 1'b0;
    in_if.kind         = K_ADD;
    in_if.accumulator  = '0;
    in_if.operand      = '0;
    in_if.flags_in     = '0;
    in_if.wide_first   = '0;
    in_if.wide_second  = '0;
    out_if.ready       = 1'b0;

    directed.push_back(mk_req(K_ADD,    8'hFF, 8'h01, 4'h0, 16'hFFFF, 16'h0000));
    directed.push_back(mk_req(K_ADC,    8'h0F, 8'h00, 4'h1, 16'h0000, 16'hFFFF));
    directed.push_back(mk_req(K_SUB,    8'h00, 8'h01, 4'h0, 16'hFFFF, 16'hFFFF));
    directed.push_back(mk_req(K_SBC,    8'h10, 8'h0F, 4'h1, 16'h0000, 16'h0000));
    directed.push_back(mk_req(K_AND,    8'hFF, 8'h00, 4'hF, 16'hFFFF, 16'h0000));
    directed.push_back(mk_req(K_XOR,    8'h5A, 8'h5A, 4'h0, 16'h0000, 16'h0000));
    directed.push_back(mk_req(K_OR,     8'h00, 8'h00, 4'hF, 16'h0000, 16'h0000));
    directed.push_back(mk_req(K_CP,     8'h3C, 8'h3C, 4'h0, 16'h0000, 16'h0000));
    directed.push_back(mk_req(K_INC,    8'h00, 8'hFF, 4'h1, 16'h0000, 16'h0000));
    directed.push_back(mk_req(K_DEC,    8'h00, 8'h01, 4'h0, 16'h0000, 16'h0000));
    directed.push_back(mk_req(K_DAA,    8'h9A, 8'h00, 4'h0, 16'h0000, 16'h0000));
    directed.push_back(mk_req(K_DAA,    8'h00, 8'h00, 4'h7, 16'h0000, 16'h0000));
    directed.push_back(mk_req(K_CPL,    8'h35, 8'h00, 4'h8, 16'h0000, 16'h0000));
    directed.push_back(mk_req(K_SCF,    8'hFF, 8'h00, 4'hF, 16'h0000, 16'h0000));
    directed.push_back(mk_req(K_CCF,    8'h00, 8'hFF, 4'h1, 16'h0000, 16'h0000));
    directed.push_back(mk_req(K_RLCA,   8'h80, 8'h00, 4'h0, 16'h0000, 16'h0000));
    directed.push_back(mk_req(K_RRCA,   8'h01, 8'h00, 4'h0, 16'h0000, 16'h0000));
    directed.push_back(mk_req(K_RLA,    8'h80, 8'h00, 4'h1, 16'h0000, 16'h0000));
    directed.push_back(mk_req(K_RRA,    8'h01, 8'h00, 4'h1, 16'h0000, 16'h0000));
    directed.push_back(mk_req(K_ADD16,  8'h00, 8'h00, 4'h8, 16'h0FFF, 16'h0001));
    directed.push_back(mk_req(K_ADD16,  8'hFF, 8'hFF, 4'h0, 16'hFFFF, 16'hFFFF));
    directed.push_back(mk_req(K_SP_OFS, 8'h00, 8'h80, 4'hF, 16'hFFFF, 16'h0000));
    directed.push_back(mk_req(K_SP_OFS, 8'h00, 8'h01, 4'h0, 16'h000F, 16'h0000));
    directed.push_back(mk_req(KIND_UNUSED_LO, 8'hA5, 8'h5A, 4'hA, 16'h1234, 16'h4321));
    directed.push_back(mk_req(KIND_UNUSED_HI, 8'hFF, 8'hFF, 4'h5, 16'hFFFF, 16'hFFFF));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_item(directed[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct  = idle_tbl[p];
      stall_pct = stall_tbl[p];
      repeat (NUM_ITEMS / NUM_PHASES) send_item(rand_req());
    end

    in_if.valid <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    while (alu_check.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (alu_check.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
